@@ design/csq_pkg.sv @@
// Package for the counting semaphore wait queue unit: request kinds, status codes,
// count bounds, register map and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package csq_pkg;

  localparam int KIND_W   = 3;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;
  localparam int INIT_W   = 15;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_OPEN     = 3'd0;
  localparam kind_t KIND_WAIT     = 3'd1;
  localparam kind_t KIND_SIGNAL   = 3'd2;
  localparam kind_t KIND_TRY_WAIT = 3'd3;
  localparam kind_t KIND_CLOSE    = 3'd4;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_TRY_FAIL = 2'd1;
  localparam status_t STATUS_BLOCKED  = 2'd2;
  localparam status_t STATUS_ERROR    = 2'd3;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  // APB register map: byte address 4*i, so the register index is paddr[2].
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_INITIAL_COUNT = 1'b0;

  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // carry out the latched request and load one result
    logic pop_close; // release the oldest waiter on behalf of close
  } csq_cmd_t;

  typedef struct packed {
    logic out_free;     // result register is empty or being taken
    logic drain_needed; // latched request is a close with threads waiting
    logic waiting_one;  // exactly one thread waits
  } csq_stat_t;

endpackage

@@ design/csq_ifs.sv @@
// Valid/ready channel interfaces for the request and result transactions.
// Depends on csq_pkg for field widths.
`timescale 1ns / 1ps

interface csq_req_if
  import csq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, kind, thread_id, input ready);
  modport sink   (input valid, kind, thread_id, output ready);
endinterface

interface csq_rsp_if
  import csq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                woken_valid;
  logic [TID_W-1:0]    woken_thread;
  logic                woken_by_close;
  logic                last;

  modport source (output valid, status, woken_valid, woken_thread, woken_by_close, last,
                  input ready);
  modport sink   (input valid, status, woken_valid, woken_thread, woken_by_close, last,
                  output ready);
endinterface

@@ design/csq_ctrl.sv @@
// Controller state machine of the semaphore unit: accepts requests and sequences
// execution and the close drain. Depends on csq_pkg.
`timescale 1ns / 1ps

module csq_ctrl
  import csq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  csq_stat_t stat,
  output csq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          if (stat.drain_needed) begin
            cmd.pop_close = 1'b1;
            state_next    = stat.waiting_one ? ST_IDLE : ST_DRAIN;
          end else begin
            cmd.exec   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.pop_close = 1'b1;
          if (stat.waiting_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/csq_datapath.sv @@
// Datapath of the semaphore unit: count, wait queue memory with head/tail pointers,
// latched request and result register. Depends on csq_pkg.
`timescale 1ns / 1ps

module csq_datapath
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  csq_cmd_t            cmd,
  output csq_stat_t           stat,
  input  logic [INIT_W-1:0]   initial_count,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [TID_W-1:0]    in_thread_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_woken_valid,
  output logic [TID_W-1:0]    out_woken_thread,
  output logic                out_woken_by_close,
  output logic                out_last
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [WAIT_W-1:0] WAIT_FULL  = WAIT_W'(QUEUE_DEPTH);
  localparam logic [WAIT_W-1:0] WAIT_ONE   = WAIT_W'(1);

  // Architectural state.
  logic signed [COUNT_W-1:0] count;
  logic [PTR_W-1:0]          head;
  logic [PTR_W-1:0]          tail;
  logic [WAIT_W-1:0]         waiting;
  logic                      is_open;

  logic signed [COUNT_W-1:0] count_next;
  logic [PTR_W-1:0]          head_next;
  logic [PTR_W-1:0]          tail_next;
  logic [WAIT_W-1:0]         waiting_next;
  logic                      is_open_next;

  // Wait queue memory; the read port follows the next head so the oldest waiter
  // is always registered and ready.
  logic [THREAD_ID_BITS-1:0] queue_mem [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0] rd_data;
  logic                      mem_we;

  // Latched request.
  kind_t                     req_kind;
  logic [THREAD_ID_BITS-1:0] req_tid;

  // Result being built.
  logic    load_res;
  status_t res_status;
  logic    res_woken_valid;
  logic    res_woken_by_close;
  logic    res_last;
  logic    res_use_rd;

  logic signed [COUNT_W-1:0]       count_inc;
  logic signed [COUNT_W-1:0]       count_dec;
  logic signed [COUNT_W-1:0]       count_init;
  logic [PTR_W-1:0]                head_adv;
  logic [PTR_W-1:0]                tail_adv;
  logic [THREAD_ID_BITS+TID_W-1:0] tid_ext;
  logic [THREAD_ID_BITS+TID_W-1:0] rd_ext;

  assign tid_ext    = {{THREAD_ID_BITS{1'b0}}, in_thread_id};
  assign rd_ext     = {{TID_W{1'b0}}, rd_data};
  assign count_inc  = (count < COUNT_MAX) ? count + 16'sd1 : count;
  assign count_dec  = (count > COUNT_MIN) ? count - 16'sd1 : count;
  assign count_init = signed'({1'b0, initial_count});
  assign head_adv   = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
  assign tail_adv   = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);

  assign stat.out_free     = !out_valid || out_ready;
  assign stat.drain_needed = (req_kind == KIND_CLOSE) && is_open && (waiting != '0);
  assign stat.waiting_one  = (waiting == WAIT_ONE);

  always_comb begin
    count_next         = count;
    head_next          = head;
    tail_next          = tail;
    waiting_next       = waiting;
    is_open_next       = is_open;
    mem_we             = 1'b0;
    load_res           = 1'b0;
    res_status         = STATUS_OK;
    res_woken_valid    = 1'b0;
    res_woken_by_close = 1'b0;
    res_last           = 1'b1;
    res_use_rd         = 1'b0;

    if (cmd.pop_close) begin
      load_res           = 1'b1;
      res_woken_valid    = 1'b1;
      res_woken_by_close = 1'b1;
      res_use_rd         = 1'b1;
      res_last           = (waiting == WAIT_ONE);
      head_next          = head_adv;
      waiting_next       = waiting - WAIT_W'(1);
      if (waiting == WAIT_ONE) begin
        head_next    = '0;
        tail_next    = '0;
        is_open_next = 1'b0;
      end
    end else if (cmd.exec) begin
      load_res = 1'b1;
      if (req_kind == KIND_OPEN) begin
        count_next   = count_init;
        head_next    = '0;
        tail_next    = '0;
        waiting_next = '0;
        is_open_next = 1'b1;
      end else if (!is_open) begin
        res_status = STATUS_ERROR;
      end else begin
        unique case (req_kind)
          KIND_WAIT: begin
            if (count <= 16'sd0) begin
              if (waiting == WAIT_FULL) begin
                res_status = STATUS_ERROR;
              end else begin
                count_next   = count_dec;
                mem_we       = 1'b1;
                tail_next    = tail_adv;
                waiting_next = waiting + WAIT_W'(1);
                res_status   = STATUS_BLOCKED;
              end
            end else begin
              count_next = count - 16'sd1;
            end
          end
          KIND_SIGNAL: begin
            count_next = count_inc;
            if ((count_inc <= 16'sd0) && (waiting != '0)) begin
              head_next       = head_adv;
              waiting_next    = waiting - WAIT_W'(1);
              res_woken_valid = 1'b1;
              res_use_rd      = 1'b1;
            end
          end
          KIND_TRY_WAIT: begin
            if (count >= 16'sd1) begin
              count_next = count - 16'sd1;
            end else begin
              res_status = STATUS_TRY_FAIL;
            end
          end
          KIND_CLOSE: begin
            // Only reached with an empty queue; a close with waiters drains instead.
            head_next    = '0;
            tail_next    = '0;
            is_open_next = 1'b0;
          end
          default: begin
            res_status = STATUS_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      waiting   <= '0;
      is_open   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count   <= count_next;
      head    <= head_next;
      tail    <= tail_next;
      waiting <= waiting_next;
      is_open <= is_open_next;
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[tail] <= req_tid;
    end
    rd_data <= queue_mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind <= in_kind;
      req_tid  <= tid_ext[THREAD_ID_BITS-1:0];
    end
    if (load_res) begin
      out_status         <= res_status;
      out_woken_valid    <= res_woken_valid;
      out_woken_thread   <= res_use_rd ? rd_ext[TID_W-1:0] : '0;
      out_woken_by_close <= res_woken_by_close;
      out_last           <= res_last;
    end
  end

endmodule

@@ design/counting_semaphore_wait_queue_unit.sv @@
// A request is accepted only while the unit is idle; the next one waits until its result is loaded.
// A close that releases n waiters offers n results, one per cycle while the result channel takes them.
// Requests are sequenced by the controller: an accept step, then one execute step per result.
// A stalled result transaction holds the unit in its execute step until it is taken.
// Reset (rst, synchronous, active high) clears count, pointers, waiting count, open flag,
// the controller state and initial_count; queue memory contents are left as they are.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_unit
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  csq_req_if.sink               req,
  csq_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // The configuration register. Writes land on the access cycle; a write to an
  // unmapped register index is dropped.
  logic [INIT_W-1:0] initial_count;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= '0;
    end else if (cfg_write && (paddr[2] == REG_INITIAL_COUNT)) begin
      initial_count <= pwdata[INIT_W-1:0];
    end
  end

  // Reads return the register value, zero elsewhere.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_INITIAL_COUNT) begin
      prdata = {{(CFG_DATA_W - INIT_W){1'b0}}, initial_count};
    end
  end

  // The controller sequences each request; the datapath holds the semaphore,
  // the wait queue and the result register that parts the two channel sides.
  csq_cmd_t  cmd;
  csq_stat_t stat;

  csq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csq_datapath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .initial_count      (initial_count),
    .in_kind            (req.kind),
    .in_thread_id       (req.thread_id),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .out_status         (rsp.status),
    .out_woken_valid    (rsp.woken_valid),
    .out_woken_thread   (rsp.woken_thread),
    .out_woken_by_close (rsp.woken_by_close),
    .out_last           (rsp.last)
  );

endmodule

@@ test/counting_semaphore_wait_queue_unit_tb.sv @@
// Self-checking testbench for counting_semaphore_wait_queue_unit: a directed table of requests,
// then random request traffic scored against a semaphore model kept inside the bench.
// Depends on csq_pkg and the csq_req_if / csq_rsp_if channel interfaces.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_unit_tb;
  import csq_pkg::*;

  localparam int QDEPTH       = 16;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DIR_ROWS     = 28;
  localparam int PHASE_ITEMS  = 25;

  // Kind encodings the unit does not define; each must answer with an error.
  localparam kind_t KIND_RSVD5 = 3'd5;
  localparam kind_t KIND_RSVD6 = 3'd6;
  localparam kind_t KIND_RSVD7 = 3'd7;

  // Where a directed row takes its expectation from.
  localparam logic BY_MODEL = 1'b0;
  localparam logic BY_TABLE = 1'b1;

  typedef enum logic {ROW_REQ, ROW_CFG} row_act_t;

  typedef struct packed {
    row_act_t           act;
    kind_t              kind;
    logic [TID_W-1:0]   tid;
    logic [INIT_W-1:0]  cfg;
    logic               typed;
    status_t            st;
  } step_row_t;

  typedef struct packed {
    status_t            status;
    logic               woken_valid;
    logic [TID_W-1:0]   woken_thread;
    logic               woken_by_close;
    logic               last;
  } reply_t;

  // Directed table. Rows marked BY_TABLE carry their expected status; the others are scored
  // by the semaphore model. Closed-semaphore errors and unknown kinds come first, then basic
  // blocking and release, reopen with waiters queued, and count saturation at the top.
  localparam step_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_CFG, KIND_OPEN,     8'h00, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_WAIT,     8'h00, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_SIGNAL,   8'hFF, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_TRY_WAIT, 8'h00, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_CLOSE,    8'hFF, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_RSVD5,    8'hFF, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_RSVD6,    8'h00, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_RSVD7,    8'hFF, 15'd0,     BY_TABLE, STATUS_ERROR},
    '{ROW_REQ, KIND_OPEN,     8'h00, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_REQ, KIND_TRY_WAIT, 8'h81, 15'd0,     BY_TABLE, STATUS_TRY_FAIL},
    '{ROW_REQ, KIND_WAIT,     8'hA5, 15'd0,     BY_TABLE, STATUS_BLOCKED},
    '{ROW_REQ, KIND_WAIT,     8'h5A, 15'd0,     BY_TABLE, STATUS_BLOCKED},
    '{ROW_REQ, KIND_SIGNAL,   8'h00, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_TRY_WAIT, 8'h7E, 15'd0,     BY_TABLE, STATUS_TRY_FAIL},
    '{ROW_REQ, KIND_CLOSE,    8'h00, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_OPEN,     8'h00, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_REQ, KIND_WAIT,     8'h3C, 15'd0,     BY_TABLE, STATUS_BLOCKED},
    '{ROW_REQ, KIND_WAIT,     8'hC3, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_OPEN,     8'h00, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_REQ, KIND_CLOSE,    8'h00, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_CFG, KIND_OPEN,     8'h00, 15'h7FFF,  BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_OPEN,     8'h00, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_REQ, KIND_SIGNAL,   8'h00, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_TRY_WAIT, 8'h00, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_REQ, KIND_SIGNAL,   8'h00, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_SIGNAL,   8'h00, 15'd0,     BY_MODEL, STATUS_OK},
    '{ROW_REQ, KIND_WAIT,     8'hFF, 15'd0,     BY_TABLE, STATUS_OK},
    '{ROW_REQ, KIND_CLOSE,    8'h00, 15'd0,     BY_TABLE, STATUS_OK}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  csq_req_if req_ch ();
  csq_rsp_if rsp_ch ();

  counting_semaphore_wait_queue_unit #(
    .QUEUE_DEPTH    (QDEPTH),
    .THREAD_ID_BITS (TID_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns clock period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Semaphore model state: a shadow of what the unit should hold after every accepted
  // request transaction, plus the shadow of the initial_count register.
  logic signed [COUNT_W-1:0] sem_count;
  logic [TID_W-1:0]          sem_fifo [QDEPTH];
  logic [3:0]                sem_head;
  logic [3:0]                sem_tail;
  logic [4:0]                sem_waiting;
  logic                      sem_open;
  logic [INIT_W-1:0]         cfg_initial_count;

  // Results still owed by the unit, oldest first.
  reply_t replies_due [$];

  // What the sender is offering right now, sampled by the scoreboard on acceptance.
  logic    offer_typed;
  status_t offer_status;

  int          mismatches;
  int          burst_left;
  int          reqs_sent;
  int unsigned cycle_count = 0;

  // Applies one request to the model and queues the result transactions it should produce.
  // A close releases the waiters oldest first, one result each, the final one carrying last.
  function automatic void sem_step(input kind_t k, input logic [TID_W-1:0] tid);
    reply_t r;
    r = '0;
    r.status = STATUS_OK;
    r.last = 1'b1;
    if (k == KIND_OPEN) begin
      sem_count = {1'b0, cfg_initial_count};
      sem_head = '0;
      sem_tail = '0;
      sem_waiting = '0;
      sem_open = 1'b1;
      replies_due.push_back(r);
    end else if (k > KIND_CLOSE || !sem_open) begin
      r.status = STATUS_ERROR;
      replies_due.push_back(r);
    end else begin
      case (k)
        KIND_WAIT: begin
          if (sem_count <= 16'sd0) begin
            // The caller would block; a full queue turns it away untouched.
            if (sem_waiting >= QDEPTH) begin
              r.status = STATUS_ERROR;
            end else begin
              if (sem_count != COUNT_MIN) sem_count = sem_count - 16'sd1;
              sem_fifo[sem_tail] = tid;
              sem_tail = sem_tail + 4'd1;
              sem_waiting = sem_waiting + 5'd1;
              r.status = STATUS_BLOCKED;
            end
          end else begin
            sem_count = sem_count - 16'sd1;
          end
          replies_due.push_back(r);
        end
        KIND_SIGNAL: begin
          if (sem_count != COUNT_MAX) sem_count = sem_count + 16'sd1;
          if (sem_count <= 16'sd0 && sem_waiting != 0) begin
            r.woken_valid = 1'b1;
            r.woken_thread = sem_fifo[sem_head];
            sem_head = sem_head + 4'd1;
            sem_waiting = sem_waiting - 5'd1;
          end
          replies_due.push_back(r);
        end
        KIND_TRY_WAIT: begin
          if (sem_count >= 16'sd1) sem_count = sem_count - 16'sd1;
          else r.status = STATUS_TRY_FAIL;
          replies_due.push_back(r);
        end
        default: begin
          // Close: with nobody waiting a single plain result comes back.
          if (sem_waiting == 0) begin
            replies_due.push_back(r);
          end
          while (sem_waiting != 0) begin
            r.woken_valid = 1'b1;
            r.woken_by_close = 1'b1;
            r.woken_thread = sem_fifo[sem_head];
            sem_head = sem_head + 4'd1;
            sem_waiting = sem_waiting - 5'd1;
            r.last = (sem_waiting == 0);
            replies_due.push_back(r);
          end
          sem_head = '0;
          sem_tail = '0;
          sem_open = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic void flag_mismatch(input string what, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected status=%0d woken=%0b thread=%02h by_close=%0b last=%0b",
               $realtime, what, want.status, want.woken_valid, want.woken_thread,
               want.woken_by_close, want.last);
      $display("[%0t] %s:      got status=%0d woken=%0b thread=%02h by_close=%0b last=%0b",
               $realtime, what, got.status, got.woken_valid, got.woken_thread,
               got.woken_by_close, got.last);
    end
  endfunction

  // Scoreboard. Results are scored before the request of the same edge is applied, since a
  // result always belongs to a request that was latched before its result register was loaded.
  always @(posedge clk) begin : scoreboard
    reply_t got;
    reply_t want;
    reply_t fixed;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.woken_valid = rsp_ch.woken_valid;
        got.woken_thread = rsp_ch.woken_thread;
        got.woken_by_close = rsp_ch.woken_by_close;
        got.last = rsp_ch.last;
        if (replies_due.size() == 0) begin
          flag_mismatch("result transaction with nothing pending", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) flag_mismatch("result transaction mismatch", want, got);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        sem_step(req_ch.kind, req_ch.thread_id);
        // Table rows answer with one plain result whose status is typed into the table;
        // the model still advances so that later rows are scored from the right state.
        if (offer_typed) begin
          fixed = '0;
          fixed.status = offer_status;
          fixed.last = 1'b1;
          void'(replies_due.pop_back());
          replies_due.push_back(fixed);
        end
      end
    end
  end

  // Result receiver: the stall pattern is redrawn periodically among always ready,
  // a coin flip per cycle, a periodic stall, and alternating runs of stalls.
  initial begin : result_sink
    int   mode;
    int   hold;
    int   tick;
    logic stalled;
    rsp_ch.ready <= 1'b0;
    mode = 0;
    hold = 0;
    tick = 0;
    stalled = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= (tick % 4 != 3);
        default: begin
          if (hold == 0) begin
            stalled = !stalled;
            hold = stalled ? $urandom_range(1, 8) : $urandom_range(1, 4);
          end
          hold--;
          rsp_ch.ready <= !stalled;
        end
      endcase
    end
  end

  // Generous run limit; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** counting_semaphore_wait_queue_unit: FAILED **");
      $finish;
    end
  end

  // Offers one request transaction and returns at the edge where it is accepted. The sender
  // runs in bursts; between bursts valid drops for a random gap with junk on the payload.
  task automatic send_request(input kind_t k, input logic [TID_W-1:0] tid,
                              input logic typed, input status_t st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      req_ch.kind <= kind_t'($urandom_range(0, 7));
      req_ch.thread_id <= TID_W'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= k;
    req_ch.thread_id <= tid;
    offer_typed <= typed;
    offer_status <= st;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    reqs_sent++;
  endtask

  // Stops the sender and waits until every owed result has come back, then waits on in case
  // the unit is still finishing its last step. The first edge lets the scoreboard log the
  // request accepted just before.
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of initial_count followed by a read back of the same register.
  task automatic program_initial_count(input logic [INIT_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_INITIAL_COUNT, 2'b00};
    pwdata <= {{(CFG_DATA_W-INIT_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_initial_count = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {{(CFG_DATA_W-INIT_W){1'b0}}, value}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] initial_count read back: expected %08h got %08h",
                 $realtime, {{(CFG_DATA_W-INIT_W){1'b0}}, value}, readback);
    end
  endtask

  // One random stretch of traffic. Most stretches are well-formed: an open, then a mix of
  // waits, signals and try-waits, usually ending in a close. Some fill the wait queue past
  // its depth before closing, so that full-queue rejection and long close drains occur.
  // The rest is raw noise over every kind, the undefined ones included.
  task automatic random_session();
    int   pick;
    int   n;
    int   w;
    kind_t k;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      send_request(KIND_OPEN, TID_W'($urandom), BY_MODEL, STATUS_OK);
      n = $urandom_range(3, 12);
      repeat (n) begin
        w = $urandom_range(0, 19);
        if (w < 8) k = KIND_WAIT;
        else if (w < 14) k = KIND_SIGNAL;
        else if (w < 18) k = KIND_TRY_WAIT;
        else if (w < 19) k = KIND_OPEN;
        else k = KIND_CLOSE;
        send_request(k, TID_W'($urandom), BY_MODEL, STATUS_OK);
      end
      if ($urandom_range(0, 9) < 7) send_request(KIND_CLOSE, TID_W'($urandom), BY_MODEL, STATUS_OK);
    end else if (pick <= 7) begin
      send_request(KIND_OPEN, TID_W'($urandom), BY_MODEL, STATUS_OK);
      n = $urandom_range(14, 19);
      repeat (n) send_request(KIND_WAIT, TID_W'($urandom), BY_MODEL, STATUS_OK);
      if ($urandom_range(0, 1) == 1) begin
        send_request(KIND_SIGNAL, TID_W'($urandom), BY_MODEL, STATUS_OK);
        send_request(KIND_WAIT, TID_W'($urandom), BY_MODEL, STATUS_OK);
      end
      send_request(KIND_CLOSE, TID_W'($urandom), BY_MODEL, STATUS_OK);
    end else begin
      n = $urandom_range(2, 8);
      repeat (n)
        send_request(kind_t'($urandom_range(0, 7)), TID_W'($urandom), BY_MODEL, STATUS_OK);
    end
  endtask

  initial begin : stimulus
    logic [INIT_W-1:0] cfg_plan [6];
    int                phase_start;

    // Everything the bench drives gets a known value before the first edge.
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_OPEN;
    req_ch.thread_id <= '0;
    offer_typed <= BY_MODEL;
    offer_status <= STATUS_OK;

    // Model matches the unit's reset state.
    sem_count = '0;
    sem_head = '0;
    sem_tail = '0;
    sem_waiting = '0;
    sem_open = 1'b0;
    cfg_initial_count = '0;
    mismatches = 0;
    burst_left = 0;
    reqs_sent = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table; register writes wait until the unit has gone idle.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].act == ROW_CFG) begin
        drain_replies();
        program_initial_count(DIRECTED[i].cfg);
      end else begin
        send_request(DIRECTED[i].kind, DIRECTED[i].tid, DIRECTED[i].typed, DIRECTED[i].st);
      end
    end

    // Random phases, each under its own initial_count: both extremes, small values that
    // let waiters pile up quickly, and two drawn at random.
    cfg_plan[0] = '0;
    cfg_plan[1] = 15'd1;
    cfg_plan[2] = 15'd3;
    cfg_plan[3] = 15'h7FFF;
    cfg_plan[4] = INIT_W'($urandom_range(0, 32767));
    cfg_plan[5] = INIT_W'($urandom_range(2, 15));
    for (int p = 0; p < 6; p++) begin
      drain_replies();
      program_initial_count(cfg_plan[p]);
      phase_start = reqs_sent;
      while (reqs_sent - phase_start < PHASE_ITEMS) random_session();
    end

    drain_replies();
    if (mismatches == 0) begin
      $display("** counting_semaphore_wait_queue_unit: PASSED **");
    end else begin
      $display("** counting_semaphore_wait_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
